[sv/binhex_char_decoder_top_defines.svh]
// assertion macros for the binhex character decoder checker
// no dependencies; included by the checker file
`ifndef BINHEX_CHAR_DECODER_TOP_DEFINES_SVH
`define BINHEX_CHAR_DECODER_TOP_DEFINES_SVH

// clocked property, ignored while reset is asserted
`define BHX_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// clocked implication, antecedent and consequent given apart
`define BHX_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

[sv/bhx_pkg.sv]
// shared types, codes and alphabet lookup for the binhex character decoder
// no dependencies
package bhx_pkg;

    localparam logic [1:0] ST_DECODED     = 2'd0;
    localparam logic [1:0] ST_NO_COLON    = 2'd1;
    localparam logic [1:0] ST_BAD_CHAR    = 2'd2;

    localparam logic [7:0] CHAR_CR        = 8'h0d;
    localparam logic [7:0] CHAR_LF        = 8'h0a;
    localparam logic [7:0] CHAR_COLON     = 8'h3a;
    localparam logic [7:0] RUN_MARK       = 8'h90;

    typedef struct packed {
        logic       valid;
        logic [5:0] sextet;
    } sextet_t;

    function automatic sextet_t sextet_lookup(input logic [7:0] ch);
        sextet_t    res;
        logic [7:0] diff;
        res.valid = 1'b1;
        case (ch) inside
            [8'h21:8'h2d]: diff = ch - 8'h21;
            [8'h30:8'h36]: diff = ch - 8'h23;
            [8'h38:8'h39]: diff = ch - 8'h24;
            [8'h40:8'h4e]: diff = ch - 8'h2a;
            [8'h50:8'h56]: diff = ch - 8'h2b;
            [8'h58:8'h5b]: diff = ch - 8'h2c;
            [8'h60:8'h66]: diff = ch - 8'h30;
            [8'h68:8'h6d]: diff = ch - 8'h31;
            [8'h70:8'h72]: diff = ch - 8'h33;
            default: begin
                diff      = 8'h00;
                res.valid = 1'b0;
            end
        endcase
        res.sextet = diff[5:0];
        return res;
    endfunction

endpackage

[sv/binhex_char_decoder_top.sv]
// binhex character decoder: one character per transfer in, at most one result out
// a result is registered and presented in the cycle after its character transfer
// throughput: one character per cycle unless m_ready stalls; output frees when it is taken
// reset: synchronous active-low aresetn clears the parser state and the output valid
// depends on bhx_pkg
module binhex_char_decoder_top
    import bhx_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_char_code,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_status,
    output logic [7:0] m_byte_value,
    output logic [7:0] m_repeat_count
);

    logic       line_seen_reg, line_seen_next;
    logic       started_reg, started_next;
    logic       halted_reg, halted_next;
    logic [1:0] phase_reg, phase_next;
    logic [5:0] leftover_reg, leftover_next;
    logic       run_pending_reg, run_pending_next;
    logic [7:0] prev_byte_reg, prev_byte_next;

    logic       m_valid_reg, m_valid_next;
    logic [1:0] status_reg;
    logic [7:0] byte_value_reg;
    logic [7:0] repeat_reg;

    logic       s_fire;
    logic       emit;
    logic [1:0] emit_status;
    logic [7:0] emit_byte;
    logic [7:0] emit_count;
    sextet_t    lookup;
    logic [7:0] packed_byte;

    assign s_ready = !m_valid_reg || m_ready;
    assign s_fire  = s_valid && s_ready;
    assign lookup  = sextet_lookup(s_char_code);

    always_comb begin
        case (phase_reg)
            2'd1:    packed_byte = {leftover_reg, lookup.sextet[5:4]};
            2'd2:    packed_byte = {leftover_reg[3:0], lookup.sextet[5:2]};
            2'd3:    packed_byte = {leftover_reg[1:0], lookup.sextet};
            default: packed_byte = 8'h00;
        endcase
    end

    always_comb begin
        line_seen_next   = line_seen_reg;
        started_next     = started_reg;
        halted_next      = halted_reg;
        phase_next       = phase_reg;
        leftover_next    = leftover_reg;
        run_pending_next = run_pending_reg;
        prev_byte_next   = prev_byte_reg;
        emit             = 1'b0;
        emit_status      = ST_DECODED;
        emit_byte        = 8'h00;
        emit_count       = 8'h00;
        if (s_fire && !halted_reg) begin
            if (s_char_code == CHAR_CR || s_char_code == CHAR_LF) begin
                line_seen_next = 1'b1;
            end else if (line_seen_reg) begin
                if (!started_reg && s_char_code != CHAR_COLON) begin
                    halted_next = 1'b1;
                    emit        = 1'b1;
                    emit_status = ST_NO_COLON;
                end else if (s_char_code != CHAR_COLON) begin
                    if (!lookup.valid) begin
                        halted_next = 1'b1;
                        emit        = 1'b1;
                        emit_status = ST_BAD_CHAR;
                    end else begin
                        leftover_next = lookup.sextet;
                        phase_next    = phase_reg + 2'd1;
                        if (phase_reg != 2'd0) begin
                            if (run_pending_reg) begin
                                run_pending_next = 1'b0;
                                if (packed_byte == 8'h00) begin
                                    prev_byte_next = RUN_MARK;
                                    emit           = 1'b1;
                                    emit_byte      = RUN_MARK;
                                    emit_count     = 8'd1;
                                end else if (packed_byte != 8'd1) begin
                                    emit       = 1'b1;
                                    emit_byte  = prev_byte_reg;
                                    emit_count = packed_byte - 8'd1;
                                end
                            end else if (packed_byte == RUN_MARK) begin
                                run_pending_next = 1'b1;
                            end else begin
                                prev_byte_next = packed_byte;
                                emit           = 1'b1;
                                emit_byte      = packed_byte;
                                emit_count     = 8'd1;
                            end
                        end
                    end
                end else begin
                    started_next = 1'b1;
                end
            end
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (s_fire) begin
            m_valid_next = emit;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_seen_reg   <= 1'b0;
            started_reg     <= 1'b0;
            halted_reg      <= 1'b0;
            phase_reg       <= 2'd0;
            leftover_reg    <= 6'd0;
            run_pending_reg <= 1'b0;
            prev_byte_reg   <= 8'h00;
            m_valid_reg     <= 1'b0;
        end else begin
            line_seen_reg   <= line_seen_next;
            started_reg     <= started_next;
            halted_reg      <= halted_next;
            phase_reg       <= phase_next;
            leftover_reg    <= leftover_next;
            run_pending_reg <= run_pending_next;
            prev_byte_reg   <= prev_byte_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    // result payload, loaded on a transfer that yields a result
    always_ff @(posedge aclk) begin
        if (s_fire && emit) begin
            status_reg     <= emit_status;
            byte_value_reg <= emit_byte;
            repeat_reg     <= emit_count;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = status_reg;
    assign m_byte_value   = byte_value_reg;
    assign m_repeat_count = repeat_reg;

endmodule

[sv/bhx_checker.sv]
// port-level checker for the binhex character decoder, bound to the top level
// depends on bhx_pkg and binhex_char_decoder_top_defines.svh
`include "binhex_char_decoder_top_defines.svh"

module bhx_checker
    import bhx_pkg::*;
(
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [1:0] m_status,
    input logic [7:0] m_byte_value,
    input logic [7:0] m_repeat_count
);

    `BHX_ASSERT_IMPL(a_error_zero_payload, m_valid && m_status != ST_DECODED, m_byte_value == 8'h00 && m_repeat_count == 8'h00, "error result with nonzero payload")
    `BHX_ASSERT_IMPL(a_count_range, m_valid && m_status == ST_DECODED, m_repeat_count != 8'h00 && m_repeat_count != 8'hff, "repeat count out of range")
    `BHX_ASSERT(a_halt_after_error, (m_valid && m_ready && m_status != ST_DECODED) |=> !m_valid, "result after error transfer")
    `BHX_ASSERT(a_out_hold, (m_valid && !m_ready) |=> (m_valid && $stable(m_status) && $stable(m_byte_value) && $stable(m_repeat_count)), "stalled result changed")

endmodule

bind binhex_char_decoder_top bhx_checker u_bhx_checker (.*);

[tb/bhx_decode_checker.sv]
`timescale 1ns / 100ps
// result checker for the binhex character decoder: watches both channels,
// predicts each character's result and compares every result transfer with it
// depends on bhx_pkg for status codes and special characters
module bhx_decode_checker
    import bhx_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic [7:0] s_char_code,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic [1:0] m_status,
    input  logic [7:0] m_byte_value,
    input  logic [7:0] m_repeat_count,
    output int         fail_count,
    output int         pending_results
);

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] value;
        logic [7:0] count;
    } decoded_byte_t;

    decoded_byte_t expected_bytes[$];

    logic       line_seen;
    logic       started;
    logic       halted;
    logic [1:0] phase;
    logic [5:0] leftover;
    logic       run_open;
    logic [7:0] prior_byte;

    // bit 6 set means not in the alphabet
    function automatic logic [6:0] sextet_of(input logic [7:0] ch);
        logic [7:0] base;
        logic [7:0] diff;
        bit         ok;
        ok = 1'b1;
        if (ch >= 8'h21 && ch <= 8'h2d)      base = 8'h21;
        else if (ch >= 8'h30 && ch <= 8'h36) base = 8'h23;
        else if (ch >= 8'h38 && ch <= 8'h39) base = 8'h24;
        else if (ch >= 8'h40 && ch <= 8'h4e) base = 8'h2a;
        else if (ch >= 8'h50 && ch <= 8'h56) base = 8'h2b;
        else if (ch >= 8'h58 && ch <= 8'h5b) base = 8'h2c;
        else if (ch >= 8'h60 && ch <= 8'h66) base = 8'h30;
        else if (ch >= 8'h68 && ch <= 8'h6d) base = 8'h31;
        else if (ch >= 8'h70 && ch <= 8'h72) base = 8'h33;
        else begin
            base = 8'h00;
            ok   = 1'b0;
        end
        diff = ch - base;
        return ok ? {1'b0, diff[5:0]} : 7'h40;
    endfunction

    function automatic bit decode_char(input logic [7:0] ch, output decoded_byte_t res);
        logic [6:0] sx;
        logic [5:0] prev_sx;
        logic [1:0] pos;
        logic [7:0] b;
        res = '{status: ST_DECODED, value: 8'h00, count: 8'h00};
        if (halted)
            return 1'b0;
        if (ch == CHAR_CR || ch == CHAR_LF) begin
            line_seen = 1'b1;
            return 1'b0;
        end
        if (!line_seen)
            return 1'b0;
        if (!started) begin
            if (ch != CHAR_COLON) begin
                halted     = 1'b1;
                res.status = ST_NO_COLON;
                return 1'b1;
            end
            started = 1'b1;
        end
        if (ch == CHAR_COLON)
            return 1'b0;
        sx = sextet_of(ch);
        if (sx[6]) begin
            halted     = 1'b1;
            res.status = ST_BAD_CHAR;
            return 1'b1;
        end
        prev_sx  = leftover;
        pos      = phase;
        leftover = sx[5:0];
        phase    = pos + 2'd1;
        case (pos)
            2'd0: return 1'b0;
            2'd1: b = {prev_sx, sx[5:4]};
            2'd2: b = {prev_sx[3:0], sx[5:2]};
            default: b = {prev_sx[1:0], sx[5:0]};
        endcase
        if (run_open) begin
            run_open = 1'b0;
            if (b != 8'h00) begin
                // count of one repeats nothing
                if (b == 8'h01)
                    return 1'b0;
                res.value = prior_byte;
                res.count = b - 8'd1;
                return 1'b1;
            end
            b = RUN_MARK;
        end else if (b == RUN_MARK) begin
            run_open = 1'b1;
            return 1'b0;
        end
        prior_byte = b;
        res.value  = b;
        res.count  = 8'd1;
        return 1'b1;
    endfunction

    always @(posedge aclk) begin
        decoded_byte_t exp_res;
        decoded_byte_t new_res;
        if (!aresetn) begin
            line_seen  = 1'b0;
            started    = 1'b0;
            halted     = 1'b0;
            phase      = 2'd0;
            leftover   = 6'd0;
            run_open   = 1'b0;
            prior_byte = 8'h00;
            expected_bytes.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_bytes.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected result transfer status %0d byte %h count %0d",
                             $time, m_status, m_byte_value, m_repeat_count);
                end else begin
                    exp_res = expected_bytes.pop_front();
                    if (m_status !== exp_res.status || m_byte_value !== exp_res.value ||
                        m_repeat_count !== exp_res.count) begin
                        fail_count++;
                        $display({"%0t: mismatch expected status %0d byte %h count %0d, ",
                                  "got status %0d byte %h count %0d"},
                                 $time, exp_res.status, exp_res.value, exp_res.count,
                                 m_status, m_byte_value, m_repeat_count);
                    end
                end
            end
            if (s_valid && s_ready) begin
                if (decode_char(s_char_code, new_res))
                    expected_bytes.push_back(new_res);
            end
        end
        pending_results <= expected_bytes.size();
    end

endmodule

[tb/tb_binhex_char_decoder_top.sv]
`timescale 1ns / 100ps
// testbench top for the binhex character decoder: builds an encoded text stream,
// drives it with random idling on both channels and gives the verdict
// depends on bhx_pkg, binhex_char_decoder_top and bhx_decode_checker
module tb_binhex_char_decoder_top
    import bhx_pkg::*;
();

    localparam int DATA_CHARS  = 700;
    localparam int IDLE_LIMIT  = 3000;
    localparam int DRAIN_LIMIT = 1000;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [7:0] s_char_code;
    logic       m_valid;
    logic       m_ready;
    logic [1:0] m_status;
    logic [7:0] m_byte_value;
    logic [7:0] m_repeat_count;

    int fail_count;
    int pending_results;
    int send_idle_pct;
    int recv_stall_pct;
    int quiet_cycles;

    logic [7:0] char_stream[$];
    logic [7:0] byte_group[$];
    bit         alpha_ok[256];

    binhex_char_decoder_top dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_char_code   (s_char_code),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_byte_value  (m_byte_value),
        .m_repeat_count(m_repeat_count)
    );

    bhx_decode_checker chk (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_char_code    (s_char_code),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_byte_value   (m_byte_value),
        .m_repeat_count (m_repeat_count),
        .fail_count     (fail_count),
        .pending_results(pending_results)
    );

    always begin
        aclk = 1'b1;
        #6;
        aclk = 1'b0;
        #6;
    end

    function automatic logic [7:0] sextet_char(input logic [5:0] s);
        logic [7:0] v;
        v = {2'b00, s};
        if (v < 8'd13)      return v + 8'h21;
        else if (v < 8'd20) return v + 8'h23;
        else if (v < 8'd22) return v + 8'h24;
        else if (v < 8'd37) return v + 8'h2a;
        else if (v < 8'd44) return v + 8'h2b;
        else if (v < 8'd48) return v + 8'h2c;
        else if (v < 8'd55) return v + 8'h30;
        else if (v < 8'd61) return v + 8'h31;
        else                return v + 8'h33;
    endfunction

    // line breaks and extra colons are skipped by the block
    task automatic emit_sextet(input logic [5:0] s);
        int pick;
        if ($urandom_range(99) < 6) begin
            pick = $urandom_range(2);
            char_stream.push_back(pick == 0 ? CHAR_CR : (pick == 1 ? CHAR_LF : CHAR_COLON));
        end
        char_stream.push_back(sextet_char(s));
    endtask

    task automatic add_byte(input logic [7:0] b);
        logic [23:0] bits;
        byte_group.push_back(b);
        if (byte_group.size() == 3) begin
            bits = {byte_group[0], byte_group[1], byte_group[2]};
            emit_sextet(bits[23:18]);
            emit_sextet(bits[17:12]);
            emit_sextet(bits[11:6]);
            emit_sextet(bits[5:0]);
            byte_group.delete();
        end
    endtask

    task automatic send_char(input logic [7:0] c);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_char_code <= c;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    always @(negedge aclk)
        m_ready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        logic [7:0] ch;
        int         kind;
        int         phase;
        int         waited;
        s_valid        = 1'b0;
        s_char_code    = 8'h00;
        aresetn        = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        for (int s = 0; s < 64; s++)
            alpha_ok[sextet_char(6'(s))] = 1'b1;

        // text before the first line break is ignored
        char_stream.push_back(8'h00);
        char_stream.push_back(8'hff);
        repeat (4) begin
            do ch = 8'($urandom_range(255)); while (ch == CHAR_CR || ch == CHAR_LF);
            char_stream.push_back(ch);
        end
        char_stream.push_back(CHAR_CR);
        char_stream.push_back(CHAR_LF);
        // occasionally a stream with no start colon
        if ($urandom_range(7) == 0) begin
            do ch = 8'($urandom_range(255));
            while (ch == CHAR_CR || ch == CHAR_LF || ch == CHAR_COLON);
            char_stream.push_back(ch);
        end
        char_stream.push_back(CHAR_COLON);

        // run before any byte, extremes, literal marker, count of one, longest run
        add_byte(RUN_MARK); add_byte(8'h05);
        add_byte(8'h00);    add_byte(8'hff);
        add_byte(RUN_MARK); add_byte(8'h00);
        add_byte(RUN_MARK); add_byte(8'h01);
        add_byte(RUN_MARK); add_byte(8'h02);
        add_byte(RUN_MARK); add_byte(8'hff);

        while (char_stream.size() < DATA_CHARS) begin
            kind = $urandom_range(99);
            if (kind < 65) begin
                add_byte(8'($urandom_range(255)));
            end else begin
                add_byte(RUN_MARK);
                kind = $urandom_range(3);
                add_byte(kind == 0 ? 8'h00 : (kind == 1 ? 8'h01 :
                         (kind == 2 ? 8'h02 : 8'($urandom_range(255)))));
            end
        end

        // invalid character ends decoding, later characters are ignored
        if ($urandom_range(1) == 0)
            ch = 8'($urandom_range(255, 128));
        else
            do ch = 8'($urandom_range(127));
            while (alpha_ok[ch] || ch == CHAR_CR || ch == CHAR_LF || ch == CHAR_COLON);
        char_stream.push_back(ch);
        repeat (6)
            char_stream.push_back(8'($urandom_range(255)));

        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (int i = 0; i < char_stream.size(); i++) begin
            phase = i * 4 / char_stream.size();
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
                default: begin send_idle_pct = 32; recv_stall_pct = 32; end
            endcase
            send_char(char_stream[i]);
        end
        s_valid <= 1'b0;

        waited = 0;
        while (pending_results != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        if (pending_results != 0) begin
            $display("%0t: %0d results never arrived", $time, pending_results);
            $display("status: fail");
        end else begin
            repeat (4) @(posedge aclk);
            if (fail_count == 0)
                $display("status: pass");
            else
                $display("status: fail");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+sv
sv/bhx_pkg.sv
sv/binhex_char_decoder_top.sv
sv/bhx_checker.sv
tb/bhx_decode_checker.sv
tb/tb_binhex_char_decoder_top.sv
